@@ hdl/efp_pkg.sv @@
// efp_pkg: shared types and constants of the event fifo with purge
// used by every file of the block; depends on nothing
`default_nettype none

package efp_pkg;

	localparam int EVT_W = 8;
	localparam int CNT_W = 4;
	localparam int OP_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PURGE = 2'd2
	} efp_op_t;

	typedef enum logic [1:0] {
		FIN_PUSH,
		FIN_POP,
		FIN_PURGE,
		FIN_NOP
	} efp_fin_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_PURGE
	} efp_state_t;

	typedef struct packed {
		logic     push;
		logic     pop_issue;
		logic     purge_init;
		logic     purge_walk;
		logic     finish;
		efp_fin_t fin;
	} efp_cmd_t;

	typedef struct packed {
		logic walk_done;
	} efp_sts_t;

	typedef struct packed {
		logic             success;
		logic [EVT_W-1:0] event_out;
		logic [CNT_W-1:0] queue_count;
		logic             queue_empty;
		logic             queue_full;
	} efp_res_t;

endpackage

`default_nettype wire

@@ hdl/efp_if.sv @@
// efp_if: valid/ready channel interfaces for requests, responses and configuration
// depends on efp_pkg
`default_nettype none

interface efp_req_if;
	logic                        valid;
	logic                        ready;
	logic [efp_pkg::OP_W-1:0]    operation;
	logic [efp_pkg::EVT_W-1:0]   event_in;

	modport source (output valid, output operation, output event_in, input ready);
	modport sink (input valid, input operation, input event_in, output ready);
endinterface

interface efp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        success;
	logic [efp_pkg::EVT_W-1:0]   event_out;
	logic [efp_pkg::CNT_W-1:0]   queue_count;
	logic                        queue_empty;
	logic                        queue_full;

	modport source (output valid, output success, output event_out, output queue_count,
		output queue_empty, output queue_full, input ready);
	modport sink (input valid, input success, input event_out, input queue_count,
		input queue_empty, input queue_full, output ready);
endinterface

interface efp_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [efp_pkg::EVT_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/efp_ctrl.sv @@
// efp_ctrl: controller state machine, decodes requests and sequences pop and purge
// depends on efp_pkg
`default_nettype none

module efp_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	input  wire logic [efp_pkg::OP_W-1:0] req_op,
	output logic                          req_ready,
	input  wire logic                     skid_full,
	input  wire efp_pkg::efp_sts_t        sts,
	output efp_pkg::efp_cmd_t             cmd
);

	efp_pkg::efp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd            = '0;
		cmd.fin        = efp_pkg::FIN_NOP;
		unique case (state_q)
			efp_pkg::ST_IDLE: begin
				req_ready = !skid_full;
				if (req_valid && !skid_full) begin
					unique case (req_op)
						efp_pkg::OP_PUSH: begin
							cmd.push   = 1'b1;
							cmd.finish = 1'b1;
							cmd.fin    = efp_pkg::FIN_PUSH;
						end
						efp_pkg::OP_POP: begin
							cmd.pop_issue = 1'b1;
							state_d       = efp_pkg::ST_POP;
						end
						efp_pkg::OP_PURGE: begin
							cmd.purge_init = 1'b1;
							state_d        = efp_pkg::ST_PURGE;
						end
						default: begin
							cmd.finish = 1'b1;
							cmd.fin    = efp_pkg::FIN_NOP;
						end
					endcase
				end
			end
			efp_pkg::ST_POP: begin
				cmd.finish = 1'b1;
				cmd.fin    = efp_pkg::FIN_POP;
				state_d    = efp_pkg::ST_IDLE;
			end
			efp_pkg::ST_PURGE: begin
				cmd.purge_walk = 1'b1;
				if (sts.walk_done) begin
					cmd.finish = 1'b1;
					cmd.fin    = efp_pkg::FIN_PURGE;
					state_d    = efp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = efp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/efp_dp.sv @@
// efp_dp: ring store, read/write indices and in-place purge compaction
// depends on efp_pkg; driven by efp_ctrl commands
`default_nettype none

module efp_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int EVENT_BITS  = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire efp_pkg::efp_cmd_t         cmd,
	input  wire logic [efp_pkg::EVT_W-1:0] event_in,
	input  wire logic [efp_pkg::EVT_W-1:0] purge_id,
	output efp_pkg::efp_sts_t              sts,
	output efp_pkg::efp_res_t              res
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CW    = IDX_W + 1;
	localparam int EXT_W = (EVENT_BITS > efp_pkg::EVT_W) ? EVENT_BITS : efp_pkg::EVT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	logic [EVENT_BITS-1:0] mem_q [QUEUE_DEPTH];
	logic [EVENT_BITS-1:0] rd_data_s1;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      w_q, r_q, p_q, k_q;
	logic                  pop_ok_q;

	logic                  empty_now, full_now, scan_more, match, keep_wr;
	logic                  push_ok, pop_ok, we, re;
	logic [IDX_W-1:0]      w_d, r_d, waddr, raddr;
	logic [EVENT_BITS-1:0] wdata, ev_st;
	logic [EXT_W-1:0]      ev_ext, rd_ext;
	logic [CW-1:0]         diff;
	logic [CW+efp_pkg::CNT_W-1:0] cnt_wide;

	assign ev_ext    = EXT_W'(event_in);
	assign ev_st     = ev_ext[EVENT_BITS-1:0];
	assign rd_ext    = EXT_W'(rd_data_s1);

	assign empty_now = (w_q == r_q);
	assign full_now  = (nxt(w_q) == r_q);
	assign scan_more = (p_q != w_q);
	assign match     = (rd_ext == EXT_W'(purge_id));
	assign keep_wr   = cmd.purge_walk && rd_valid_s1 && !match;
	assign push_ok   = cmd.push && !full_now;
	assign pop_ok    = cmd.pop_issue && !empty_now;

	assign we    = push_ok || keep_wr;
	assign waddr = push_ok ? w_q : k_q;
	assign wdata = push_ok ? ev_st : rd_data_s1;
	assign re    = pop_ok || (cmd.purge_walk && scan_more);
	assign raddr = pop_ok ? r_q : p_q;

	assign sts.walk_done = !scan_more && !rd_valid_s1;

	always_comb begin
		w_d = w_q;
		if (push_ok) begin
			w_d = nxt(w_q);
		end else if (cmd.finish && (cmd.fin == efp_pkg::FIN_PURGE)) begin
			w_d = k_q;
		end
	end

	assign r_d = pop_ok ? nxt(r_q) : r_q;

	always_comb begin
		diff = CW'(w_d) - CW'(r_d);
		if (w_d < r_d) begin
			diff = diff + CW'(QUEUE_DEPTH);
		end
	end

	assign cnt_wide = (CW + efp_pkg::CNT_W)'(diff);

	always_comb begin
		res.queue_count = cnt_wide[efp_pkg::CNT_W-1:0];
		res.queue_empty = (w_d == r_d);
		res.queue_full  = (nxt(w_d) == r_d);
		res.success     = 1'b0;
		res.event_out   = '0;
		case (cmd.fin)
			efp_pkg::FIN_PUSH: begin
				res.success = !full_now;
			end
			efp_pkg::FIN_POP: begin
				res.success = pop_ok_q;
				if (pop_ok_q) begin
					res.event_out = rd_ext[efp_pkg::EVT_W-1:0];
				end
			end
			efp_pkg::FIN_PURGE: begin
				res.success = 1'b1;
			end
			efp_pkg::FIN_NOP: begin
				res.success = 1'b0;
			end
		endcase
	end

	// store and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_s1 <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= '0;
			r_q         <= '0;
			p_q         <= '0;
			k_q         <= '0;
			pop_ok_q    <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			w_q         <= w_d;
			r_q         <= r_d;
			rd_valid_s1 <= cmd.purge_walk && scan_more;
			if (cmd.pop_issue) begin
				pop_ok_q <= pop_ok;
			end
			// survivors are rewritten behind the scan, starting at the oldest slot
			if (cmd.purge_init) begin
				p_q <= r_q;
				k_q <= r_q;
			end else begin
				if (cmd.purge_walk && scan_more) begin
					p_q <= nxt(p_q);
				end
				if (keep_wr) begin
					k_q <= nxt(k_q);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/efp_obuf.sv @@
// efp_obuf: response register with a skid slot in front of the response channel
// depends on efp_pkg and efp_if
`default_nettype none

module efp_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	input  wire efp_pkg::efp_res_t res,
	output logic                   skid_full,
	efp_rsp_if.source              rsp
);

	efp_pkg::efp_res_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              out_take;

	assign out_take  = out_valid_q && rsp.ready;
	assign skid_full = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q && out_take) begin
				skid_valid_q <= 1'b0;
			end else if (res_valid) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && out_take) begin
			out_q <= skid_q;
		end else if (res_valid) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.success     = out_q.success;
	assign rsp.event_out   = out_q.event_out;
	assign rsp.queue_count = out_q.queue_count;
	assign rsp.queue_empty = out_q.queue_empty;
	assign rsp.queue_full  = out_q.queue_full;

endmodule

`default_nettype wire

@@ hdl/event_fifo_with_purge_top.sv @@
// event_fifo_with_purge_top: push and bad-code beats give a registered response, one request
// per cycle back to back while the skid slot is free; pop gives its response after the
// registered store read; purge scans the n queued entries through the single read port
// before its response. responses wait in a register plus skid slot. reset clears indices,
// purge id and handshake state; store stays undefined
// depends on efp_pkg, efp_if, efp_ctrl, efp_dp, efp_obuf
`default_nettype none

module event_fifo_with_purge_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int EVENT_BITS  = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	efp_req_if.sink   req,
	efp_rsp_if.source rsp,
	efp_cfg_if.sink   cfg
);

	logic [efp_pkg::EVT_W-1:0] purge_id_q;
	efp_pkg::efp_cmd_t         cmd;
	efp_pkg::efp_sts_t         sts;
	efp_pkg::efp_res_t         res;
	logic                      skid_full;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			purge_id_q <= '0;
		end else if (cfg.valid) begin
			purge_id_q <= cfg.data;
		end
	end

	efp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.operation),
		.req_ready (req.ready),
		.skid_full (skid_full),
		.sts       (sts),
		.cmd       (cmd)
	);

	efp_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.EVENT_BITS  (EVENT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.event_in (req.event_in),
		.purge_id (purge_id_q),
		.sts      (sts),
		.res      (res)
	);

	efp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (cmd.finish),
		.res       (res),
		.skid_full (skid_full),
		.rsp       (rsp)
	);

	a_no_result_into_full_skid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !skid_full)
		else $error("result produced while skid slot occupied");

	a_empty_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.queue_empty && rsp.queue_full))
		else $error("response shows empty and full together");

	a_empty_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.queue_empty) |-> (rsp.queue_count == '0))
		else $error("empty response with nonzero count");

	a_failed_beat_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.success) |-> (rsp.event_out == '0))
		else $error("event returned on failed beat");

endmodule

`default_nettype wire
